// ----- sv/bba_pkg.sv -----
// Shared constants, types and helpers for the bitmap block allocator.
// No dependencies.
`default_nettype none
package bba_pkg;

  localparam int NUM_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam int BLOCK_W = 12;                      // width of block number fields
  localparam int ADDR_W  = $clog2(MAP_WORDS);
  localparam int BIT_W   = $clog2(MAP_WORD_BITS);

  // valid blocks in the last map word; bits above them read as used
  localparam int TAIL_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * MAP_WORD_BITS;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

  localparam logic [MAP_WORD_BITS-1:0] TAIL_MASK =
    {MAP_WORD_BITS{1'b1}} << TAIL_BITS;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;
  typedef logic [ADDR_W-1:0]        map_addr_t;
  typedef logic [BIT_W-1:0]         bit_idx_t;
  typedef logic [BLOCK_W-1:0]       block_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // one cycle of map memory traffic
  typedef struct packed {
    logic      re;
    map_addr_t raddr;
    logic      we;
    map_addr_t waddr;
    map_word_t wdata;
  } map_req_t;

endpackage
`default_nettype wire

// ----- sv/bba_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on bba_pkg.
`default_nettype none
interface bba_in_if;
  logic          valid;
  logic          ready;
  logic          op;
  bba_pkg::block_t block_id;

  modport source (output valid, output op, output block_id, input ready);
  modport sink   (input valid, input op, input block_id, output ready);
endinterface

interface bba_out_if;
  logic          valid;
  logic          ready;
  bba_pkg::block_t granted_block;
  logic          ok;

  modport source (output valid, output granted_block, output ok, input ready);
  modport sink   (input valid, input granted_block, input ok, output ready);
endinterface
`default_nettype wire

// ----- sv/bba_map_ram.sv -----
// Usage map memory: one read and one write port, registered read data.
// Per-word valid bits make unwritten words read as all free. Depends on bba_pkg.
`default_nettype none
module bba_map_ram (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bba_pkg::map_req_t  req,
  output bba_pkg::map_word_t      rd_data
);

  bba_pkg::map_word_t                 mem [bba_pkg::MAP_WORDS];
  logic [bba_pkg::MAP_WORDS-1:0]      word_valid;
  bba_pkg::map_word_t                 rd_raw;
  logic                               rd_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_raw <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (req.re) begin
        rd_valid <= word_valid[req.raddr];
      end
      if (req.we) begin
        word_valid[req.waddr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule
`default_nettype wire

// ----- sv/bba_zero_find.sv -----
// Lowest-clear-bit finder for one map word.
// Depends on bba_pkg.
`default_nettype none
module bba_zero_find (
  input  wire bba_pkg::map_word_t word,
  output logic                    found,
  output bba_pkg::bit_idx_t       idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = bba_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        idx   = bba_pkg::BIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/bitmap_block_allocator.sv -----
// Top level of the first-fit bitmap block allocator: request sequencer,
// result register, start register. Depends on bba_pkg, bba_if, bba_map_ram, bba_zero_find.
`default_nettype none
// Channel     Dir  Payload                      Transaction when
// in_ch       in   op, block_id                 in_ch.valid & in_ch.ready
// out_ch      out  granted_block, ok            out_ch.valid & out_ch.ready
// cfg         in   cfg_data -> first_data_block cfg_we
//
// Allocate: the sequencer reads map words from the start word upward, 1 to 128
// of them, until a clear bit is found or the last word has been scanned; then the
// result register is loaded and the next request can be taken. One map word is read per cycle from the
// memory's single read port. Free: read, then write back, then the result
// register.
// Reset clears the start register to 1 and the per-word valid bits, so the
// whole map reads free right away; no request is taken while rst is high.
// A new request is taken as soon as the previous result sits in the output
// register, even if the sink has not yet taken it; a blocked sink holds the
// sequencer in its result state.
module bitmap_block_allocator (
  input  wire logic              clk,
  input  wire logic              rst,
  bba_in_if.sink                 in_ch,
  bba_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire bba_pkg::block_t   cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FREE = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;

  bba_pkg::block_t     first_data_block;

  // request context
  bba_pkg::map_addr_t  cur_addr;       // address of the word on rd_data
  bba_pkg::bit_idx_t   start_bit;      // lowest allowed bit in the first word
  logic                first_word;     // rd_data is the first scanned word
  bba_pkg::bit_idx_t   free_bit;

  // pending result
  bba_pkg::block_t     res_block;
  logic                res_ok;

  // output register
  logic                out_valid;
  bba_pkg::block_t     out_block;
  logic                out_ok;

  bba_pkg::map_req_t   req;
  bba_pkg::map_word_t  rd_data;
  bba_pkg::map_word_t  scan_word;
  logic                zf_found;
  bba_pkg::bit_idx_t   zf_idx;

  logic                accept;
  logic                can_load;
  bba_pkg::block_t     start;
  bba_pkg::block_t     start_word;
  bba_pkg::block_t     id_word;
  logic                start_past_end;
  logic                id_out_of_range;

  bba_map_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  bba_zero_find u_find (
    .word  (scan_word),
    .found (zf_found),
    .idx   (zf_idx)
  );

  assign in_ch.ready = (state == ST_IDLE) && !rst;
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_load    = !out_valid || out_ch.ready;

  // zero start register behaves as 1: block 0 is the "none" value
  assign start           = (first_data_block == '0) ? bba_pkg::BLOCK_W'(1) : first_data_block;
  assign start_word      = start >> bba_pkg::BIT_W;
  assign id_word         = in_ch.block_id >> bba_pkg::BIT_W;
  assign start_past_end  = (32'(start) >= 32'(bba_pkg::NUM_BLOCKS));
  assign id_out_of_range = (32'(in_ch.block_id) >= 32'(bba_pkg::NUM_BLOCKS));

  // bits below the start block and past the last block count as used
  always_comb begin
    scan_word = rd_data;
    if (first_word) begin
      scan_word = scan_word | ~({bba_pkg::MAP_WORD_BITS{1'b1}} << start_bit);
    end
    if (cur_addr == bba_pkg::LAST_ADDR) begin
      scan_word = scan_word | bba_pkg::TAIL_MASK;
    end
  end

  // sequencer and memory requests
  always_comb begin
    state_next = state;
    req        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.op)
            bba_pkg::OP_ALLOC: begin
              if (start_past_end) begin
                state_next = ST_RESP;
              end else begin
                req.re     = 1'b1;
                req.raddr  = start_word[bba_pkg::ADDR_W-1:0];
                state_next = ST_SCAN;
              end
            end
            bba_pkg::OP_FREE: begin
              if (id_out_of_range) begin
                state_next = ST_RESP;
              end else begin
                req.re     = 1'b1;
                req.raddr  = id_word[bba_pkg::ADDR_W-1:0];
                state_next = ST_FREE;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (zf_found) begin
          req.we     = 1'b1;
          req.waddr  = cur_addr;
          req.wdata  = rd_data | (bba_pkg::MAP_WORD_BITS'(1) << zf_idx);
          state_next = ST_RESP;
        end else if (cur_addr == bba_pkg::LAST_ADDR) begin
          state_next = ST_RESP;          // map full
        end else begin
          req.re    = 1'b1;
          req.raddr = cur_addr + bba_pkg::ADDR_W'(1);
        end
      end
      ST_FREE: begin
        req.we     = 1'b1;
        req.waddr  = cur_addr;
        req.wdata  = rd_data & ~(bba_pkg::MAP_WORD_BITS'(1) << free_bit);
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      first_data_block <= bba_pkg::BLOCK_W'(1);
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        first_data_block <= cfg_data;
      end
      if (state == ST_RESP && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request context and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_block  <= '0;
      res_ok     <= 1'b0;
      first_word <= 1'b1;
      if (in_ch.op == bba_pkg::OP_ALLOC) begin
        cur_addr  <= start_word[bba_pkg::ADDR_W-1:0];
        start_bit <= start[bba_pkg::BIT_W-1:0];
      end else begin
        cur_addr <= id_word[bba_pkg::ADDR_W-1:0];
        free_bit <= in_ch.block_id[bba_pkg::BIT_W-1:0];
        res_ok   <= !id_out_of_range;
      end
    end
    if (state == ST_SCAN) begin
      first_word <= 1'b0;
      if (zf_found) begin
        res_block <= bba_pkg::BLOCK_W'({cur_addr, zf_idx});
        res_ok    <= 1'b1;
      end else if (cur_addr != bba_pkg::LAST_ADDR) begin
        cur_addr <= cur_addr + bba_pkg::ADDR_W'(1);
      end
    end
    if (state == ST_RESP && can_load) begin
      out_block <= res_block;
      out_ok    <= res_ok;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.granted_block = out_block;
  assign out_ch.ok            = out_ok;

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for bitmap_block_allocator: directed table, then random phases.
// Results are checked against a bit-accurate usage-map predictor kept in the bench.
// Depends on bba_pkg, bba_if and the allocator RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 72;
  localparam int SETTLE       = 4;       // idle cycles before a start-register write
  localparam int DRAIN_CYCLES = 140;     // longest allocate scan plus margin
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_PRINTS   = 60;
  localparam int DIR_ROWS     = 21;

  // one result transaction as the sink sees it
  typedef struct packed {
    bba_pkg::block_t granted;
    logic            ok;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // directed row: a request, or a start-register write (arg is the value)
  typedef struct packed {
    row_kind_t       kind;
    logic            op;
    bba_pkg::block_t arg;
    logic            typed;      // expected result given in the row itself
    bba_pkg::block_t exp_block;
    logic            exp_ok;
  } dir_row_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  bba_pkg::block_t cfg_data;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  bitmap_block_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // predictor state: one bit per block (1 = used) and the start register
  logic [bba_pkg::NUM_BLOCKS-1:0] used_bits;
  bba_pkg::block_t                start_reg;

  grant_t          grant_q[$];   // results still owed by the block, oldest first
  bba_pkg::block_t live_q[$];    // blocks handed out and not yet freed by the bench

  dir_row_t dir_tab [DIR_ROWS];

  int errors;
  int cycles;
  int n_granted;
  int n_refused;
  int n_freed;
  int n_cfg;
  bit steady;           // when set, neither side inserts gaps

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Gap length shared by sender and receiver: mostly none or short,
  // now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // First-fit allocate / plain-clear free over the predicted usage map.
  function automatic grant_t bitmap_apply(input logic op, input bba_pkg::block_t id);
    grant_t g;
    int     lo;
    g = '0;
    if (op == bba_pkg::OP_ALLOC) begin
      // start register of zero behaves as one: block 0 means "none"
      lo = (start_reg == '0) ? 1 : int'(start_reg);
      for (int b = lo; b < bba_pkg::NUM_BLOCKS; b++) begin
        if (!used_bits[b]) begin
          used_bits[b] = 1'b1;
          g.granted    = bba_pkg::block_t'(b);
          g.ok         = 1'b1;
          break;
        end
      end
    end else if (int'(id) < bba_pkg::NUM_BLOCKS) begin
      // free clears the bit even when already clear or below the start
      used_bits[id] = 1'b0;
      g.ok          = 1'b1;
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH @%0t %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Send one request transaction. valid is only lowered when a gap follows,
  // so back-to-back transactions never see two assignments in one step.
  task automatic issue(input logic op, input bba_pkg::block_t id, input logic typed,
                       input grant_t typed_res);
    int     gap;
    grant_t g;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.block_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    // accepted at this edge: update the predictor in acceptance order
    g = bitmap_apply(op, id);
    if (op == bba_pkg::OP_ALLOC && g.ok) live_q.push_back(g.granted);
    grant_q.push_back(typed ? typed_res : g);
  endtask

  // Start-register write, only once every owed result has come back.
  task automatic write_start_reg(input bba_pkg::block_t v);
    in_ch.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_reg  = v;
    n_cfg++;
  endtask

  // Result side: random back-pressure, and every transaction is checked
  // field by field against the oldest owed result.
  always @(posedge clk) begin : result_side
    grant_t want;
    int     stall_left;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_ch.granted_block), -1);
        end else begin
          want = grant_q.pop_front();
          if (out_ch.granted_block !== want.granted)
            report_mismatch("granted_block", int'(out_ch.granted_block),
                            int'(want.granted));
          if (out_ch.ok !== want.ok)
            report_mismatch("ok", int'(out_ch.ok), int'(want.ok));
          if (!want.ok) n_refused++;
          else if (want.granted != '0) n_granted++;
          else n_freed++;
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycles, grant_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int              r;
    int              idx;
    bba_pkg::block_t start_val;
    bba_pkg::block_t id;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= bba_pkg::OP_ALLOC;
    in_ch.block_id <= '0;
    n_cfg     = 0;
    steady    = 1'b0;
    used_bits = '0;
    start_reg = bba_pkg::block_t'(1);

    // Directed part. Expected results are typed in where obvious from the
    // reset state or the register extremes; other rows use the predictor.
    dir_tab = '{
      // fresh map, start at 1: first grants are 1 then 2 (block_id ignored)
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 1'b1, 12'd1,   1'b1},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'hFFF, 1'b1, 12'd2,   1'b1},
      '{ROW_REQ, bba_pkg::OP_FREE,  12'd1,   1'b1, 12'd0,   1'b1},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h5A5, 1'b0, 12'd0,   1'b0},
      // free of block 0, of an already free top block, alternating bit ids
      '{ROW_REQ, bba_pkg::OP_FREE,  12'h000, 1'b1, 12'd0,   1'b1},
      '{ROW_REQ, bba_pkg::OP_FREE,  12'hFFF, 1'b1, 12'd0,   1'b1},
      '{ROW_REQ, bba_pkg::OP_FREE,  12'hAAA, 1'b1, 12'd0,   1'b1},
      '{ROW_REQ, bba_pkg::OP_FREE,  12'h555, 1'b1, 12'd0,   1'b1},
      '{ROW_REQ, bba_pkg::OP_FREE,  12'd2,   1'b1, 12'd0,   1'b1},
      // start at the last block: one grant, then the map is full
      '{ROW_CFG, bba_pkg::OP_ALLOC, 12'hFFF, 1'b0, 12'd0,   1'b0},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 1'b1, 12'hFFF, 1'b1},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 1'b1, 12'd0,   1'b0},
      '{ROW_REQ, bba_pkg::OP_FREE,  12'hFFF, 1'b1, 12'd0,   1'b1},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 1'b0, 12'd0,   1'b0},
      // free below the start still clears the bit
      '{ROW_REQ, bba_pkg::OP_FREE,  12'd1,   1'b1, 12'd0,   1'b1},
      // start of zero acts as one
      '{ROW_CFG, bba_pkg::OP_ALLOC, 12'h000, 1'b0, 12'd0,   1'b0},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 1'b1, 12'd1,   1'b1},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 1'b0, 12'd0,   1'b0},
      '{ROW_CFG, bba_pkg::OP_ALLOC, 12'h800, 1'b0, 12'd0,   1'b0},
      '{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 1'b0, 12'd0,   1'b0},
      '{ROW_CFG, bba_pkg::OP_ALLOC, 12'h001, 1'b0, 12'd0,   1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_start_reg(dir_tab[i].arg);
      else
        issue(dir_tab[i].op, dir_tab[i].arg, dir_tab[i].typed,
              {dir_tab[i].exp_block, dir_tab[i].exp_ok});
    end

    // Random phases, one start-register setting each. Most frees name a
    // block the bench was granted earlier; some name any block at all.
    // The starts at 4064 and at the last block leave a handful of blocks, so the map fills up and
    // refusals show up; one phase runs with no gaps on either side.
    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0:       start_val = bba_pkg::block_t'($urandom_range(1, 40));
        1:       start_val = '0;
        2:       start_val = bba_pkg::block_t'(4064);
        3:       start_val = bba_pkg::block_t'($urandom_range(2000, 4000));
        4:       start_val = '1;
        default: start_val = bba_pkg::block_t'(1);
      endcase
      write_start_reg(start_val);
      steady = (p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 55 || live_q.size() == 0) begin
          issue(bba_pkg::OP_ALLOC, bba_pkg::block_t'($urandom), 1'b0, '0);
        end else if (r < 90) begin
          idx = $urandom_range(0, live_q.size() - 1);
          id  = live_q[idx];
          live_q.delete(idx);
          issue(bba_pkg::OP_FREE, id, 1'b0, '0);
        end else begin
          issue(bba_pkg::OP_FREE, bba_pkg::block_t'($urandom), 1'b0, '0);
        end
      end
    end
    steady = 1'b0;

    // drain: everything owed, then a quiet window for stray results
    in_ch.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d grants, %0d refusals, %0d frees", n_granted, n_refused, n_freed);
    $display("across %0d start-register writes, %0d mismatches", n_cfg, errors);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
sv/bba_pkg.sv
sv/bba_if.sv
sv/bba_map_ram.sv
sv/bba_zero_find.sv
sv/bitmap_block_allocator.sv
sim/tb.sv
